// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the pool allocator modules. The macros expect
// the enclosing module to have a clock named clk and an active-low reset
// named rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, prop)

`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types, codes and field widths shared by the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // field widths of one request and one result item
  localparam int REQ_W      = 2;
  localparam int BNUM_W     = 8;
  localparam int ADDR_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int RBLK_W     = 6;
  localparam int FCOUNT_W   = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC     = 2'd0,
    REQ_FREE_NUM  = 2'd1,
    REQ_FREE_ADDR = 2'd2,
    REQ_QUERY     = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_BAD_ADDR  = 2'd2,
    STS_BAD_BLOCK = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_EXEC = 2'd2,
    S_OUT  = 2'd3
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, issue stack read
    logic div_step;  // one step of the two-step offset divide
    logic exec;      // update stack, load result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic new_free_addr;  // incoming item is a free by address
    logic div_last;       // divide finishes this cycle
  } ctrl_sts_t;

endpackage

// ===== rtl/fixed_block_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Pool allocator for equal-sized blocks, kept on a LIFO stack of free block
// numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream (tuser = request kind, tdata = block
//   number and address); each yields exactly one result item on the out_
//   stream (tuser = status, tdata = block, address, free count).
//   The user must write pool_base through cfg_wr_en / cfg_wr_data only while
//   idle; the block itself does not enforce this. An accepted request goes
//   to the execute step, which loads the result register; a free by address
//   first divides its offset by BLOCK_BYTES (reciprocal multiply step, then
//   remainder step). One item at a time: a new item is taken only after the
//   result of the last one has been taken on the out_ stream.
//   The free stack sits in a RAM with registered read; a pop reads it in the
//   cycle before the execute step.
//   Reset: the stack holds every block, block 0 on top; a low-water mark
//   stands in for the reset contents, so there is no clearing pass.
//   When out_tready is low the result is held and in_tready stays low.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit #(
  parameter int NUM_BLOCKS  = 64,
  parameter int BLOCK_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] block_number, [39:8] address
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [5:0] result_block, [37:6] result_address,
                                  // [44:38] free_count, [47:45] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  import fbpa_pkg::*;

  ctrl_cmd_t             cmd;
  ctrl_sts_t             sts;
  status_t               res_status;
  logic [RBLK_W-1:0]     res_block;
  logic [ADDR_W-1:0]     res_address;
  logic [FCOUNT_W-1:0]   res_count;

  fbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  fbpa_datapath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_req_type        (in_tuser),
    .in_block_number    (in_tdata[7:0]),
    .in_address         (in_tdata[39:8]),
    .cmd                (cmd),
    .sts                (sts),
    .out_status         (res_status),
    .out_result_block   (res_block),
    .out_result_address (res_address),
    .out_free_count     (res_count)
  );

  assign out_tdata = {3'b000, res_count, res_address, res_block};
  assign out_tuser = res_status;

endmodule

// ===== rtl/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: accept an item, run the offset divide when needed,
// execute the stack update and hold the result until it is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbpa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output fbpa_pkg::ctrl_cmd_t   cmd,
  input  fbpa_pkg::ctrl_sts_t   sts
);

  import fbpa_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   in_fire;

  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = sts.new_free_addr ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        if (sts.div_last) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.exec     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
      end
    endcase
  end

  `ASSERT_NEXT(a_accept_starts_work, in_fire, (state_r == S_DIV) || (state_r == S_EXEC))
  `ASSERT_NEXT(a_exec_then_out, cmd.exec, out_tvalid)
  `ASSERT_NEXT(a_out_holds, out_tvalid && !out_tready, out_tvalid && !in_tready)

endmodule

// ===== rtl/fbpa_datapath.sv =====
// ----------------------------------------------------------------------------
// fbpa_datapath
// Free stack, depth and low-water mark, offset divider, address multiply
// and result register of the pool allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fbpa_datapath #(
  parameter int NUM_BLOCKS  = 64,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [fbpa_pkg::ADDR_W-1:0]     cfg_wr_data,
  input  logic [fbpa_pkg::REQ_W-1:0]      in_req_type,
  input  logic [fbpa_pkg::BNUM_W-1:0]     in_block_number,
  input  logic [fbpa_pkg::ADDR_W-1:0]     in_address,
  input  fbpa_pkg::ctrl_cmd_t             cmd,
  output fbpa_pkg::ctrl_sts_t             sts,
  output fbpa_pkg::status_t               out_status,
  output logic [fbpa_pkg::RBLK_W-1:0]     out_result_block,
  output logic [fbpa_pkg::ADDR_W-1:0]     out_result_address,
  output logic [fbpa_pkg::FCOUNT_W-1:0]   out_free_count
);

  import fbpa_pkg::*;

  localparam int BLK_W = $clog2(NUM_BLOCKS);
  localparam int DEP_W = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned SPAN = NUM_BLOCKS * BLOCK_BYTES;
  // reciprocal of BLOCK_BYTES, exact for every offset below SPAN
  localparam int OFF_W  = $clog2(SPAN);
  localparam int RCP_S  = OFF_W + $clog2(BLOCK_BYTES);
  localparam int RCP_W  = OFF_W + 2;
  localparam int PROD_W = OFF_W + RCP_W;
  localparam longint unsigned RCP_M =
    ((64'd1 << RCP_S) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
  localparam logic [RCP_W-1:0]  RCP_M_V = RCP_W'(RCP_M);
  localparam logic [ADDR_W-1:0] BB_A   = ADDR_W'(BLOCK_BYTES);
  localparam logic [ADDR_W-1:0] SPAN_A = ADDR_W'(SPAN);
  localparam logic [DEP_W-1:0]  NB_D   = DEP_W'(NUM_BLOCKS);
  localparam logic [BNUM_W:0]   NB_B   = (BNUM_W + 1)'(NUM_BLOCKS);

  // configuration and captured request
  logic [ADDR_W-1:0] pool_base_r;
  req_t              req_r;
  logic [BNUM_W-1:0] bnum_r;
  logic [ADDR_W-1:0] addr_r;

  // offset divider
  logic [ADDR_W-1:0] rem_r;
  logic [BLK_W-1:0]  quo_r;
  logic              cnt_r;
  logic              range_err_r;
  logic [ADDR_W-1:0] in_offset;
  logic [PROD_W-1:0] rcp_prod;
  logic [ADDR_W-1:0] quo_back;

  // stack state; entries below the low-water mark still hold reset values
  logic [DEP_W-1:0]  depth_r;
  logic [DEP_W-1:0]  depth_nxt;
  logic [DEP_W-1:0]  min_r;
  logic [DEP_W-1:0]  min_nxt;
  logic [DEP_W-1:0]  depth_dec;
  logic [DEP_W-1:0]  rst_val;
  logic [BLK_W-1:0]  ram_rdata;
  logic [BLK_W-1:0]  pop_blk;

  // execute
  status_t           status_c;
  logic [BLK_W-1:0]  blk_c;
  logic              push_c;
  logic              pop_c;
  logic              ram_we;
  logic [ADDR_W-1:0] mul_addr;
  logic [ADDR_W-1:0] raddr_c;

  assign in_offset = in_address - pool_base_r;
  assign rcp_prod  = PROD_W'(rem_r[OFF_W-1:0]) * PROD_W'(RCP_M_V);
  assign quo_back  = ADDR_W'(quo_r) * BB_A;

  assign sts.new_free_addr = (req_t'(in_req_type) == REQ_FREE_ADDR);
  assign sts.div_last      = (cnt_r == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= '0;
    end else if (cfg_wr_en) begin
      pool_base_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r       <= req_t'(in_req_type);
      bnum_r      <= in_block_number;
      addr_r      <= in_address;
      rem_r       <= in_offset;
      range_err_r <= in_offset >= SPAN_A;
      quo_r       <= '0;
      cnt_r       <= 1'b1;
    end else if (cmd.div_step) begin
      // first step takes the quotient, second leaves the remainder
      if (cnt_r) begin
        quo_r <= rcp_prod[RCP_S +: BLK_W];
      end else begin
        rem_r <= rem_r - quo_back;
      end
      cnt_r <= 1'b0;
    end
  end

  assign depth_dec = depth_r - DEP_W'(1);
  assign rst_val   = NB_D - depth_r;
  assign pop_blk   = (depth_r == min_r) ? rst_val[BLK_W-1:0] : ram_rdata;

  always_comb begin
    status_c = STS_OK;
    blk_c    = '0;
    push_c   = 1'b0;
    pop_c    = 1'b0;
    unique case (req_r)
      REQ_ALLOC: begin
        if (depth_r != '0) begin
          blk_c = pop_blk;
          pop_c = 1'b1;
        end else begin
          status_c = STS_EMPTY;
        end
      end
      REQ_FREE_NUM, REQ_QUERY: begin
        if ({1'b0, bnum_r} < NB_B) begin
          blk_c  = bnum_r[BLK_W-1:0];
          push_c = (req_r == REQ_FREE_NUM);
        end else begin
          status_c = STS_BAD_BLOCK;
        end
      end
      REQ_FREE_ADDR: begin
        if (range_err_r || (rem_r != '0)) begin
          status_c = STS_BAD_ADDR;
        end else begin
          blk_c  = quo_r;
          push_c = 1'b1;
        end
      end
    endcase
  end

  assign mul_addr = pool_base_r + ADDR_W'(blk_c) * BB_A;
  assign raddr_c  = (status_c != STS_OK)     ? '0 :
                    (req_r == REQ_FREE_ADDR) ? addr_r : mul_addr;

  // drop the push when the stack is already full
  assign ram_we = cmd.exec && push_c && (depth_r != NB_D);

  always_comb begin
    depth_nxt = depth_r;
    min_nxt   = min_r;
    if (ram_we) begin
      depth_nxt = depth_r + DEP_W'(1);
    end else if (pop_c) begin
      depth_nxt = depth_dec;
      if (depth_r == min_r) begin
        min_nxt = depth_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= NB_D;
      min_r   <= NB_D;
    end else if (cmd.exec) begin
      depth_r <= depth_nxt;
      min_r   <= min_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status         <= status_c;
      out_result_block   <= RBLK_W'(blk_c);
      out_result_address <= raddr_c;
      out_free_count     <= FCOUNT_W'(depth_nxt);
    end
  end

  fbpa_ram #(
    .WIDTH (BLK_W),
    .DEPTH (NUM_BLOCKS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth_r[BLK_W-1:0]),
    .wdata (blk_c),
    .re    (cmd.load),
    .raddr (depth_dec[BLK_W-1:0]),
    .rdata (ram_rdata)
  );

  `ASSERT_ALWAYS(a_depth_bound, depth_r <= NB_D)
  `ASSERT_ALWAYS(a_mark_below_depth, min_r <= depth_r)
  `ASSERT_NEXT(a_error_keeps_stack, cmd.exec && (status_c != STS_OK), $stable(depth_r))

endmodule
